@@ hw/rtl/rfd_pkg.sv @@
package rfd_pkg;

    // Stream and register widths
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned ERR_W        = 3;
    localparam int unsigned VERSION_W    = 16;
    localparam int unsigned TYPE_W       = 8;
    localparam int unsigned REQ_ID_W     = 64;
    localparam int unsigned LENGTH_W     = 32;
    localparam int unsigned MAGIC_W      = 32;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned PHASE_W      = 2;
    localparam int unsigned OUT_TDATA_W  = 144;
    localparam int unsigned APB_ADDR_W   = 5;
    localparam int unsigned APB_DATA_W   = 32;

    // Header layout: byte positions where each field ends
    localparam logic [POS_W-1:0] POS_MAGIC_END   = 5'd4;
    localparam logic [POS_W-1:0] POS_VERSION_END = 5'd6;
    localparam logic [POS_W-1:0] POS_MSG_TYPE    = 5'd6;
    localparam logic [POS_W-1:0] POS_CODEC_TYPE  = 5'd7;
    localparam logic [POS_W-1:0] POS_REQ_ID_END  = 5'd16;
    localparam logic [POS_W-1:0] POS_LAST_HEADER = 5'd19;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_HEADER = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BODY   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DROP   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BODY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_MAGIC    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_VERSION  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_MSG_TYPE = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CODEC    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TOO_BIG  = 3'd4;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_MAGIC     = 3'd0;
    localparam logic [2:0] REG_VERSION   = 3'd1;
    localparam logic [2:0] REG_MIN_TYPE  = 3'd2;
    localparam logic [2:0] REG_MAX_TYPE  = 3'd3;
    localparam logic [2:0] REG_MAX_CODEC = 3'd4;
    localparam logic [2:0] REG_MAX_BODY  = 3'd5;

    // Register reset values
    localparam logic [MAGIC_W-1:0]   RST_MAGIC     = 32'd0;
    localparam logic [VERSION_W-1:0] RST_VERSION   = 16'd1;
    localparam logic [TYPE_W-1:0]    RST_MIN_TYPE  = 8'd0;
    localparam logic [TYPE_W-1:0]    RST_MAX_TYPE  = 8'd255;
    localparam logic [TYPE_W-1:0]    RST_MAX_CODEC = 8'd255;
    localparam logic [LENGTH_W-1:0]  RST_MAX_BODY  = 32'd65536;

endpackage

@@ hw/rtl/rpc_frame_deframer_unit.sv @@
// Length-prefixed frame deframer.
// Slave stream (s_*): one received byte per item; s_tuser marks the first byte
// of a new stream, which restarts header parsing and leaves the error state.
// Each frame opens with a 20-byte big-endian header (magic, version, message
// type, codec type, request id, body length). At the last header byte the
// header is checked against the APB registers; a failure gives one error item
// and drops bytes until the next start-of-stream byte. A good header gives one
// header item (tlast set when the body is empty), then one body item per body
// byte, the final one with tlast.
// A result item is registered and presented in the cycle after its byte is taken.
// Throughput: one byte per cycle while the master side does not stall; all
// decoding sits between the slave handshake and a single output register.
// Reset clears the parser to the start of a header and loads the register
// defaults. When the master side stalls, the output register holds its item
// and s_tready falls, so no byte is taken until the held item leaves.
// Register writes are meant only while the block is idle.
module rpc_frame_deframer_unit
    import rfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] start_of_stream

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] version, [23:16] msg_type, [31:24] codec,
    // [95:32] req_id, [127:96] body_length, [135:128] body_byte,
    // [138:136] error_code, [143:139] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]      m_tuser,   // [1:0] kind
    output logic                   m_tlast,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Configuration registers
    logic [MAGIC_W-1:0]   exp_magic_reg;
    logic [VERSION_W-1:0] exp_version_reg;
    logic [TYPE_W-1:0]    min_type_reg;
    logic [TYPE_W-1:0]    max_type_reg;
    logic [TYPE_W-1:0]    max_codec_reg;
    logic [LENGTH_W-1:0]  max_body_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_magic_reg   <= RST_MAGIC;
            exp_version_reg <= RST_VERSION;
            min_type_reg    <= RST_MIN_TYPE;
            max_type_reg    <= RST_MAX_TYPE;
            max_codec_reg   <= RST_MAX_CODEC;
            max_body_reg    <= RST_MAX_BODY;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAGIC:     exp_magic_reg   <= pwdata;
                REG_VERSION:   exp_version_reg <= pwdata[VERSION_W-1:0];
                REG_MIN_TYPE:  min_type_reg    <= pwdata[TYPE_W-1:0];
                REG_MAX_TYPE:  max_type_reg    <= pwdata[TYPE_W-1:0];
                REG_MAX_CODEC: max_codec_reg   <= pwdata[TYPE_W-1:0];
                REG_MAX_BODY:  max_body_reg    <= pwdata;
                default:       ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (cfg_index)
            REG_MAGIC:     prdata = exp_magic_reg;
            REG_VERSION:   prdata = {16'd0, exp_version_reg};
            REG_MIN_TYPE:  prdata = {24'd0, min_type_reg};
            REG_MAX_TYPE:  prdata = {24'd0, max_type_reg};
            REG_MAX_CODEC: prdata = {24'd0, max_codec_reg};
            REG_MAX_BODY:  prdata = max_body_reg;
            default:       prdata = '0;
        endcase
    end

    // Parser state. The header shift registers are fully refilled for every
    // header before they are checked, so they need no clearing.
    logic [PHASE_W-1:0]   phase_reg,   phase_next;
    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic [LENGTH_W-1:0]  remain_reg,  remain_next;
    logic [MAGIC_W-1:0]   magic_reg,   magic_next;
    logic [VERSION_W-1:0] version_reg, version_next;
    logic [TYPE_W-1:0]    msg_reg,     msg_next;
    logic [TYPE_W-1:0]    codec_reg,   codec_next;
    logic [REQ_ID_W-1:0]  req_id_reg,  req_id_next;
    logic [LENGTH_W-1:0]  length_reg,  length_next;

    // Output register
    logic                   out_valid_reg;
    logic [KIND_W-1:0]      out_kind_reg,  out_kind_next;
    logic [OUT_TDATA_W-1:0] out_data_reg,  out_data_next;
    logic                   out_last_reg,  out_last_next;
    logic                   res_valid;

    logic                 in_fire;
    logic [PHASE_W-1:0]   eff_phase;
    logic [POS_W-1:0]     eff_pos;
    logic [LENGTH_W-1:0]  remain_dec;
    logic [ERR_W-1:0]     err_code;
    logic                 err_found;

    // Take a byte whenever the output register is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Start of stream restarts the header in any phase
    assign eff_phase  = s_tuser ? PH_HEADER : phase_reg;
    assign eff_pos    = s_tuser ? '0 : pos_reg;
    assign remain_dec = remain_reg - 1'b1;

    // Shift the header byte into its field
    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        msg_next     = msg_reg;
        codec_next   = codec_reg;
        req_id_next  = req_id_reg;
        length_next  = length_reg;
        if (eff_phase == PH_HEADER)
        begin
            priority if (eff_pos < POS_MAGIC_END)
                magic_next = {magic_reg[MAGIC_W-BYTE_W-1:0], s_tdata};
            else if (eff_pos < POS_VERSION_END)
                version_next = {version_reg[VERSION_W-BYTE_W-1:0], s_tdata};
            else if (eff_pos == POS_MSG_TYPE)
                msg_next = s_tdata;
            else if (eff_pos == POS_CODEC_TYPE)
                codec_next = s_tdata;
            else if (eff_pos < POS_REQ_ID_END)
                req_id_next = {req_id_reg[REQ_ID_W-BYTE_W-1:0], s_tdata};
            else
                length_next = {length_reg[LENGTH_W-BYTE_W-1:0], s_tdata};
        end
    end

    // Header checks, first failure wins
    always_comb
    begin
        err_found = 1'b1;
        err_code  = ERR_MAGIC;
        priority if (magic_next != exp_magic_reg)
            err_code = ERR_MAGIC;
        else if (version_next != exp_version_reg)
            err_code = ERR_VERSION;
        else if (msg_next < min_type_reg || msg_next > max_type_reg)
            err_code = ERR_MSG_TYPE;
        else if (codec_next > max_codec_reg)
            err_code = ERR_CODEC;
        else if (length_next > max_body_reg)
            err_code = ERR_TOO_BIG;
        else
            err_found = 1'b0;
    end

    // Phase sequencing and result building
    always_comb
    begin
        phase_next    = eff_phase;
        pos_next      = eff_pos;
        remain_next   = s_tuser ? '0 : remain_reg;
        res_valid     = 1'b0;
        out_kind_next = KIND_HEADER;
        out_data_next = '0;
        out_last_next = 1'b0;

        unique case (eff_phase)
            PH_BODY:
            begin
                res_valid     = 1'b1;
                out_kind_next = KIND_BODY;
                out_data_next[135:128] = s_tdata;
                remain_next   = remain_dec;
                if (remain_dec == '0)
                begin
                    out_last_next = 1'b1;
                    phase_next    = PH_HEADER;
                    pos_next      = '0;
                end
            end
            PH_HEADER:
            begin
                if (eff_pos != POS_LAST_HEADER)
                begin
                    pos_next = eff_pos + 1'b1;
                end
                else
                begin
                    res_valid = 1'b1;
                    pos_next  = '0;
                    if (err_found)
                    begin
                        out_kind_next          = KIND_ERROR;
                        out_data_next[138:136] = err_code;
                        phase_next             = PH_DROP;
                    end
                    else
                    begin
                        out_kind_next          = KIND_HEADER;
                        out_data_next[15:0]    = version_next;
                        out_data_next[23:16]   = msg_next;
                        out_data_next[31:24]   = codec_next;
                        out_data_next[95:32]   = req_id_next;
                        out_data_next[127:96]  = length_next;
                        if (length_next == '0)
                        begin
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            remain_next = length_next;
                            phase_next  = PH_BODY;
                        end
                    end
                end
            end
            default:
            begin
                // Drop the byte
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            remain_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
            msg_reg     <= msg_next;
            codec_reg   <= codec_next;
            req_id_reg  <= req_id_next;
            length_reg  <= length_next;
        end
    end

    // Hold the result until taken; refill as it leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= in_fire && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    // Run limits: cycles with no handshake at all before giving up, length
    // of the deliberate output hold-off, and settle time once drained.
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 40;
    localparam int unsigned SETTLE      = 4;

    // Addresses past the last register; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;    // [7:0] data_byte
    logic                   s_tuser;    // [0] start_of_stream

    logic                   m_tvalid;
    logic                   m_tready;
    // [15:0] version, [23:16] msg_type, [31:24] codec,
    // [95:32] req_id, [127:96] body_length, [135:128] body_byte,
    // [138:136] error_code, [143:139] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;    // [1:0] kind
    logic                   m_tlast;

    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // One result item as the deframer should emit it
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [VERSION_W-1:0] version;
        logic [TYPE_W-1:0]    msg_type;
        logic [TYPE_W-1:0]    codec;
        logic [REQ_ID_W-1:0]  req_id;
        logic [LENGTH_W-1:0]  body_length;
        logic [BYTE_W-1:0]    body_byte;
        logic                 last;
        logic [ERR_W-1:0]     error_code;
    } frame_result_t;

    // Results still owed by the block, oldest first
    frame_result_t pending_results[$];

    // Shadow copy of the registers
    logic [MAGIC_W-1:0]   cfg_magic;
    logic [VERSION_W-1:0] cfg_version;
    logic [TYPE_W-1:0]    cfg_min_type;
    logic [TYPE_W-1:0]    cfg_max_type;
    logic [TYPE_W-1:0]    cfg_max_codec;
    logic [LENGTH_W-1:0]  cfg_max_body;

    // Shadow copy of the parser
    logic [PHASE_W-1:0]   fp_phase;
    logic [POS_W-1:0]     hdr_pos;
    logic [MAGIC_W-1:0]   hdr_magic;
    logic [VERSION_W-1:0] hdr_version;
    logic [TYPE_W-1:0]    hdr_msg_type;
    logic [TYPE_W-1:0]    hdr_codec;
    logic [REQ_ID_W-1:0]  hdr_req_id;
    logic [LENGTH_W-1:0]  hdr_length;
    logic [LENGTH_W-1:0]  fp_remaining;

    int unsigned mismatches;
    int unsigned live_items;     // items that the parser did not drop
    int unsigned burst_pct;      // chance of an idle burst, per byte sent and per receiver check
    bit          idle_mode;      // random traffic may idle at all
    bit          long_hold_req;  // ask the receiver for one long hold-off
    int unsigned stall_left;
    int unsigned quiet_cycles;

    rpc_frame_deframer_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function automatic void clear_header();
        hdr_pos      = '0;
        hdr_magic    = '0;
        hdr_version  = '0;
        hdr_msg_type = '0;
        hdr_codec    = '0;
        hdr_req_id   = '0;
        hdr_length   = '0;
    endfunction

    // Advance the shadow parser by one accepted byte and queue the result
    // it causes. Return 0 when the byte is simply dropped.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, input logic sos);
        frame_result_t    r;
        logic             fail;
        logic [ERR_W-1:0] code;
        r    = '0;
        fail = 1'b1;
        code = ERR_MAGIC;
        // a start-of-stream byte always opens a fresh header
        if (sos)
        begin
            fp_phase     = PH_HEADER;
            clear_header();
            fp_remaining = '0;
        end
        if (fp_phase == PH_DROP)
            return 1'b0;
        if (fp_phase == PH_BODY)
        begin
            r.kind       = KIND_BODY;
            r.body_byte  = b;
            fp_remaining = fp_remaining - 1'b1;
            if (fp_remaining == '0)
            begin
                r.last   = 1'b1;
                fp_phase = PH_HEADER;
                clear_header();
            end
            pending_results.insert(pending_results.size(), r);
            return 1'b1;
        end
        // header bytes arrive big-endian, field by field
        if (hdr_pos < POS_MAGIC_END)
            hdr_magic = {hdr_magic[MAGIC_W-9:0], b};
        else if (hdr_pos < POS_VERSION_END)
            hdr_version = {hdr_version[VERSION_W-9:0], b};
        else if (hdr_pos == POS_MSG_TYPE)
            hdr_msg_type = b;
        else if (hdr_pos == POS_CODEC_TYPE)
            hdr_codec = b;
        else if (hdr_pos < POS_REQ_ID_END)
            hdr_req_id = {hdr_req_id[REQ_ID_W-9:0], b};
        else
            hdr_length = {hdr_length[LENGTH_W-9:0], b};
        if (hdr_pos != POS_LAST_HEADER)
        begin
            hdr_pos = hdr_pos + 1'b1;
            return 1'b1;
        end
        // last header byte: first failing check wins
        if (hdr_magic != cfg_magic)
            code = ERR_MAGIC;
        else if (hdr_version != cfg_version)
            code = ERR_VERSION;
        else if (hdr_msg_type < cfg_min_type || hdr_msg_type > cfg_max_type)
            code = ERR_MSG_TYPE;
        else if (hdr_codec > cfg_max_codec)
            code = ERR_CODEC;
        else if (hdr_length > cfg_max_body)
            code = ERR_TOO_BIG;
        else
            fail = 1'b0;
        if (fail)
        begin
            r.kind       = KIND_ERROR;
            r.error_code = code;
            fp_phase     = PH_DROP;
        end
        else
        begin
            r.kind        = KIND_HEADER;
            r.version     = hdr_version;
            r.msg_type    = hdr_msg_type;
            r.codec       = hdr_codec;
            r.req_id      = hdr_req_id;
            r.body_length = hdr_length;
            r.last        = (hdr_length == '0);
            if (hdr_length == '0)
                fp_phase = PH_HEADER;
            else
            begin
                fp_remaining = hdr_length;
                fp_phase     = PH_BODY;
            end
        end
        clear_header();
        pending_results.insert(pending_results.size(), r);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every accepted result against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected item kind", '0, m_tuser);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    flag_mismatch("kind", want.kind, m_tuser);
                if (m_tdata[15:0] !== want.version)
                    flag_mismatch("version", want.version, m_tdata[15:0]);
                if (m_tdata[23:16] !== want.msg_type)
                    flag_mismatch("msg_type", want.msg_type, m_tdata[23:16]);
                if (m_tdata[31:24] !== want.codec)
                    flag_mismatch("codec", want.codec, m_tdata[31:24]);
                if (m_tdata[95:32] !== want.req_id)
                    flag_mismatch("req_id", want.req_id, m_tdata[95:32]);
                if (m_tdata[127:96] !== want.body_length)
                    flag_mismatch("body_length", want.body_length, m_tdata[127:96]);
                if (m_tdata[135:128] !== want.body_byte)
                    flag_mismatch("body_byte", want.body_byte, m_tdata[135:128]);
                if (m_tdata[138:136] !== want.error_code)
                    flag_mismatch("error_code", want.error_code, m_tdata[138:136]);
                if (m_tdata[143:139] !== '0)
                    flag_mismatch("tdata padding", '0, m_tdata[143:139]);
                if (m_tlast !== want.last)
                    flag_mismatch("last", want.last, m_tlast);
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off on request so the
    // output register fills and the block has to stall its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (long_hold_req)
        begin
            long_hold_req <= 1'b0;
            m_tready      <= 1'b0;
            stall_left    <= LONG_HOLD - 1;
        end
        else if (burst_pct != 0 && $urandom_range(0, 99) < burst_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------

    task automatic reg_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the register takes the value at this edge
        case (idx)
            REG_MAGIC:     cfg_magic     = val;
            REG_VERSION:   cfg_version   = val[VERSION_W-1:0];
            REG_MIN_TYPE:  cfg_min_type  = val[TYPE_W-1:0];
            REG_MAX_TYPE:  cfg_max_type  = val[TYPE_W-1:0];
            REG_MAX_CODEC: cfg_max_codec = val[TYPE_W-1:0];
            REG_MAX_BODY:  cfg_max_body  = val;
            default:       ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic expect_register(input logic [2:0] idx, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want)
            flag_mismatch($sformatf("register %0d read", idx), want, got);
    endtask

    task automatic check_registers();
        expect_register(REG_MAGIC, cfg_magic);
        expect_register(REG_VERSION, {16'd0, cfg_version});
        expect_register(REG_MIN_TYPE, {24'd0, cfg_min_type});
        expect_register(REG_MAX_TYPE, {24'd0, cfg_max_type});
        expect_register(REG_MAX_CODEC, {24'd0, cfg_max_codec});
        expect_register(REG_MAX_BODY, cfg_max_body);
    endtask

    task automatic apply_setting(input logic [31:0] magic, input logic [15:0] ver,
                                 input logic [7:0] min_type, input logic [7:0] max_type,
                                 input logic [7:0] max_codec, input logic [31:0] max_body);
        reg_write(REG_MAGIC, magic);
        reg_write(REG_VERSION, {16'd0, ver});
        reg_write(REG_MIN_TYPE, {24'd0, min_type});
        reg_write(REG_MAX_TYPE, {24'd0, max_type});
        reg_write(REG_MAX_CODEC, {24'd0, max_codec});
        reg_write(REG_MAX_BODY, max_body);
        check_registers();
    endtask

    // ------------------------------------------------------------------
    // Stream sending
    // ------------------------------------------------------------------

    // Offer one byte, maybe after an idle burst, and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic sos);
        if (burst_pct != 0 && $urandom_range(0, 99) < burst_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sos;
        do @(posedge clk); while (s_tready !== 1'b1);
        if (deframe_byte(b, sos))
            live_items++;
    endtask

    // Stop offering and hold until every owed result has left, then settle
    // long enough for any header byte still in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_frame(input logic sos0, input logic [31:0] magic,
                              input logic [15:0] ver, input logic [7:0] mtype,
                              input logic [7:0] codec, input logic [63:0] rid,
                              input logic [31:0] blen, input int unsigned body_sent);
        logic [159:0] hdr;
        hdr = {magic, ver, mtype, codec, rid, blen};
        for (int i = 0; i < 20; i++)
            send_byte(hdr[159 - 8*i -: 8], (i == 0) ? sos0 : 1'b0);
        repeat (body_sent) send_byte(8'($urandom), 1'b0);
    endtask

    // A header cut short: n bytes, the first opening a new stream
    task automatic send_stub(input int unsigned n);
        send_byte(8'($urandom), 1'b1);
        repeat (n - 1) send_byte(8'($urandom), 1'b0);
    endtask

    function automatic logic [7:0] legal_type();
        if (cfg_min_type <= cfg_max_type)
            return 8'($urandom_range(cfg_max_type, cfg_min_type));
        return 8'($urandom);
    endfunction

    task automatic send_good_frame(input logic sos0, input logic [31:0] blen,
                                   input int unsigned body_sent);
        send_frame(sos0, cfg_magic, cfg_version, legal_type(),
                   8'($urandom_range(cfg_max_codec, 0)), {$urandom, $urandom},
                   blen, body_sent);
    endtask

    // Mostly short bodies, now and then a long one, never above the limit
    function automatic int unsigned pick_length();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 19);
        if (r < 15)
            len = $urandom_range(0, 6);
        else if (r < 19)
            len = $urandom_range(7, 40);
        else
            len = $urandom_range(41, 200);
        if (len > cfg_max_body)
            len = cfg_max_body;
        return len;
    endfunction

    // Random traffic under the current setting until quota bytes have been
    // parsed: mostly well-formed frames, the rest broken or cut-off frames
    // and stray bytes.
    task automatic random_traffic(input int unsigned quota);
        int unsigned      stop_at;
        int unsigned      pick;
        int unsigned      len;
        logic             sos0;
        logic [31:0]      mg;
        logic [15:0]      vr;
        logic [7:0]       mt;
        logic [7:0]       cd;
        logic [31:0]      bl;
        stop_at = live_items + quota;
        while (live_items < stop_at)
        begin
            // idle in stretches, with quiet frames in between
            burst_pct = (idle_mode && $urandom_range(0, 3) != 0) ? 20 : 0;
            // a frame may follow a complete one without a start marker
            sos0 = (fp_phase == PH_HEADER && hdr_pos == '0) ? 1'($urandom) : 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = pick_length();
                send_good_frame(sos0, len, len);
            end
            else if (pick < 80)
            begin
                // spoil one header field, then trail a few bytes
                mg = cfg_magic;
                vr = cfg_version;
                mt = legal_type();
                cd = 8'($urandom_range(cfg_max_codec, 0));
                bl = pick_length();
                case ($urandom_range(0, 4))
                    0:       mg = mg ^ ($urandom | 32'd1);
                    1:       vr = vr ^ 16'($urandom_range(1, 65535));
                    2:       mt = 8'($urandom);
                    3:       cd = 8'($urandom);
                    default: bl = cfg_max_body + $urandom_range(1, 3);
                endcase
                send_frame(sos0, mg, vr, mt, cd, {$urandom, $urandom}, bl,
                           $urandom_range(0, 3));
            end
            else if (pick < 90)
            begin
                // cut a frame off in its header or its body
                if (cfg_max_body == 0 || $urandom_range(0, 1) == 0)
                    send_stub($urandom_range(1, 19));
                else
                begin
                    bl = (cfg_max_body > 40 && $urandom_range(0, 1) == 0)
                       ? $urandom_range(cfg_max_body, 1)
                       : $urandom_range((cfg_max_body > 40) ? 40 : cfg_max_body, 1);
                    send_good_frame(1'b1, bl, $urandom_range(0, (bl > 10) ? 10 : bl - 1));
                end
            end
            else
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_defaults();
        check_registers();
    endtask

    // Every check, in its order of precedence, and the recovery paths
    task automatic test_header_checks();
        logic [31:0] m;
        logic [15:0] v;
        burst_pct = 20;
        // defaults: magic zero, version one; empty body flags the header last
        send_frame(1'b1, 32'd0, 16'd1, 8'd0, 8'd0, 64'd0, 32'd0, 0);
        // back-to-back without a start marker, all-ones fields
        send_frame(1'b0, 32'd0, 16'd1, 8'hFF, 8'hFF, '1, 32'd2, 2);
        wait_idle();
        m = 32'hA5C3_0F1E;
        v = 16'h8001;
        apply_setting(m, v, 8'd10, 8'd20, 8'd3, 32'd300);
        // everything wrong: magic reported, then stray bytes are dropped
        send_frame(1'b1, m ^ 32'h8000_0000, v ^ 16'h0001, 8'd0, 8'd9, '1, 32'd999, 0);
        repeat (3) send_byte(8'($urandom), 1'b0);
        // version wrong with type wrong too
        send_frame(1'b1, m, v ^ 16'h8000, 8'd0, 8'd9, 64'd1, 32'd0, 0);
        // type just below the range with a bad codec too, then just above it
        send_frame(1'b1, m, v, 8'd9, 8'd4, 64'd2, 32'd0, 0);
        send_frame(1'b1, m, v, 8'd21, 8'd0, 64'd3, 32'd0, 0);
        // codec one past its bound, with an oversized body too
        send_frame(1'b1, m, v, 8'd10, 8'd4, 64'd4, 32'd301, 0);
        // body one past its limit
        send_frame(1'b1, m, v, 8'd20, 8'd3, 64'd5, 32'd301, 0);
        // body right at its limit, cut off after one byte
        send_frame(1'b1, m, v, 8'd10, 8'd0, {$urandom, $urandom}, 32'd300, 1);
        send_frame(1'b1, m, v, 8'd15, 8'd3, 64'd0, 32'd0, 0);
        // header cut short, then a full frame and one straight after it
        send_stub(7);
        send_frame(1'b1, m, v, 8'd12, 8'd1, {$urandom, $urandom}, 32'd3, 3);
        send_frame(1'b0, m, v, 8'd20, 8'd3, {$urandom, $urandom}, 32'd1, 1);
        wait_idle();
        // empty type range: no type can pass
        apply_setting(m, v, 8'd30, 8'd20, 8'd255, 32'd0);
        send_frame(1'b1, m, v, 8'd25, 8'd0, 64'd6, 32'd0, 0);
        send_frame(1'b1, m, v, 8'd30, 8'd0, 64'd7, 32'd0, 0);
        wait_idle();
        // writes past the last register leave every register alone
        reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_HI, 32'h5A5A_5A5A);
        check_registers();
    endtask

    // Hold the output long enough to fill the block while bytes keep coming
    task automatic test_output_hold();
        apply_setting($urandom, 16'($urandom), 8'd0, 8'd255, 8'd255, 32'd65536);
        burst_pct     = 0;
        long_hold_req = 1'b1;
        send_good_frame(1'b1, 32'd48, 48);
        wait_idle();
    endtask

    // Sender stops mid-body until the block has handed everything over
    task automatic test_sender_pause();
        burst_pct = 20;
        send_good_frame(1'b1, 32'd20, 8);
        wait_idle();
        repeat (12) send_byte(8'($urandom), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_settings();
        logic [7:0] lo;
        idle_mode = 1'b1;
        apply_setting($urandom, 16'($urandom), 8'd0, 8'd255, 8'd255, 32'd64);
        random_traffic(30);
        wait_idle();
        // top extremes, one legal type, bodies must be empty
        lo = 8'($urandom);
        apply_setting(32'hFFFF_FFFF, 16'hFFFF, lo, lo, 8'd0, 32'd0);
        random_traffic(30);
        wait_idle();
        // bottom extremes, no effective body limit
        apply_setting(32'd0, 16'd0, 8'd0, 8'd255, 8'd255, 32'hFFFF_FFFF);
        random_traffic(30);
        wait_idle();
        lo = 8'($urandom_range(0, 200));
        apply_setting($urandom, 16'($urandom), lo, lo + 8'($urandom_range(0, 55)),
                      8'($urandom), $urandom_range(1, 40));
        random_traffic(30);
        wait_idle();
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        idle_mode = 1'b0;
        random_traffic(40);
        wait_idle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        live_items    = 0;
        burst_pct     = 0;
        idle_mode     = 1'b0;
        long_hold_req = 1'b0;
        stall_left    = 0;
        quiet_cycles  = 0;
        cfg_magic     = RST_MAGIC;
        cfg_version   = RST_VERSION;
        cfg_min_type  = RST_MIN_TYPE;
        cfg_max_type  = RST_MAX_TYPE;
        cfg_max_codec = RST_MAX_CODEC;
        cfg_max_body  = RST_MAX_BODY;
        fp_phase      = PH_HEADER;
        fp_remaining  = '0;
        clear_header();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_header_checks();
        test_output_hold();
        test_sender_pause();
        test_random_settings();
        test_full_rate();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
